// ----- src/msb_pkg.sv -----
// Package: shared widths, codes and beat types of the selection bitmap block.
`timescale 1ns / 1ps
package msb_pkg;

  // Field widths
  localparam int IDX_W   = 13;
  localparam int FOCUS_W = 12;
  localparam int OP_W    = 3;
  localparam int ITEM_MAX = (2 ** IDX_W) - 1;

  // Parameter defaults
  localparam int DEF_MAX_ITEMS = 4096;
  localparam int DEF_WORD_BITS = 64;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // Operation codes on the input beat
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd1;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
  localparam logic [OP_W-1:0] OP_RANGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  // Command kinds handed to the back end
  localparam logic [1:0] KIND_NOP  = 2'd0;  // answer from registers only
  localparam logic [1:0] KIND_BIT  = 2'd1;  // read-modify-write of one word
  localparam logic [1:0] KIND_FILL = 2'd2;  // sweep every word with a span

  // Single-bit operations
  localparam logic [1:0] BOP_ADD    = 2'd0;
  localparam logic [1:0] BOP_TOGGLE = 2'd1;
  localparam logic [1:0] BOP_QUERY  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] anchor;
  } msb_in_t;

  typedef struct packed {
    logic               is_selected;
    logic [FOCUS_W-1:0] focus;
    logic [IDX_W-1:0]   selected_count;
  } msb_out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       bop;
    logic             qin;       // queried index below item count
    logic [IDX_W-1:0] idx;       // clamped index, new focus
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] fill_cnt;
    logic             fill_sel;
  } msb_cmd_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] n;         // saturated item count
  } msb_cfg_t;

endpackage

// ----- src/multi_select_bitmap_top.sv -----
// Top level of the selection bitmap with focus and population count.
//
//  channel  ports                       direction  beat
//  input    push, full, in_data         in         operation, index, anchor
//  result   pop, empty, out_data        out        is_selected, focus, selected_count
//  config   cfg_we, cfg_item_count      in         item count, no wait, no read-back
//
// A query, add or toggle reads its row in the back end, then writes it back; an
// operation with nothing to do answers from registers. Select-only and range rewrite
// every row of the bitmap RAM, one row per cycle. After reset the RAM is cleared with
// full held high; an item count write starts the same sweep. The 2-entry command queue
// keeps accepting beats while a result waits on the output register.
`timescale 1ns / 1ps
module multi_select_bitmap_top
  import msb_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  msb_in_t          in_data,
  input  logic             pop,
  output logic             empty,
  output msb_out_t         out_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_item_count
);

  logic     q_full, q_empty, q_wr, q_rd, busy;
  msb_cmd_t q_wdata, q_rdata;
  msb_cfg_t cfg_ev;

  msb_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .cfg_we         (cfg_we),
    .cfg_item_count (cfg_item_count),
    .q_full         (q_full),
    .busy           (busy),
    .q_wr           (q_wr),
    .q_wdata        (q_wdata),
    .cfg_ev         (cfg_ev)
  );

  msb_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  msb_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_rdata),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_rd),
    .cfg_ev    (cfg_ev),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .busy      (busy)
  );

endmodule

// ----- src/msb_cmdq.sv -----
// Short command queue between the classifying front end and the bitmap back end.
`timescale 1ns / 1ps
module msb_cmdq
  import msb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  msb_cmd_t wr_data,
  input  logic     rd_en,
  output msb_cmd_t rd_data,
  output logic     q_full,
  output logic     q_empty
);

  localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  msb_cmd_t         ent_r [CMDQ_DEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == QCW'(CMDQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = ent_r[rptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : QAW'(wptr_r + QAW'(1));
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : QAW'(rptr_r + QAW'(1));
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = QCW'(cnt_r + QCW'(1));
    end else if (do_rd && !do_wr) begin
      cnt_nxt = QCW'(cnt_r - QCW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/msb_front.sv -----
// Front end: item count register, input beat acceptance and command classification.
`timescale 1ns / 1ps
module msb_front
  import msb_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  msb_in_t          in_data,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_item_count,
  input  logic             q_full,
  input  logic             busy,
  output logic             q_wr,
  output msb_cmd_t         q_wdata,
  output msb_cfg_t         cfg_ev
);

  localparam int SAT_ITEMS = (MAX_ITEMS > ITEM_MAX) ? ITEM_MAX : MAX_ITEMS;

  logic [IDX_W-1:0] n_r;
  logic [IDX_W-1:0] n_sat;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] q_idx, clamp_idx, clamp_anc, span_lo, span_hi;
  logic             q_in, anc_in;

  // Saturate the written item count
  assign n_sat = (cfg_item_count > IDX_W'(SAT_ITEMS)) ? IDX_W'(SAT_ITEMS) : cfg_item_count;
  assign cfg_ev.we = cfg_we;
  assign cfg_ev.n  = n_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (cfg_we) begin
      n_r <= n_sat;
    end
  end

  // Hold off beats while the queue is full or the clearing pass after reset runs
  assign full = q_full || busy;
  assign q_wr = push && !full;

  // Clamp indices at the top and order the span ends
  assign q_idx     = in_data.index;
  assign last_idx  = IDX_W'(n_r - IDX_W'(1));
  assign q_in      = (q_idx < n_r);
  assign anc_in    = (in_data.anchor < n_r);
  assign clamp_idx = q_in ? q_idx : last_idx;
  assign clamp_anc = anc_in ? in_data.anchor : last_idx;
  assign span_lo   = (clamp_anc < clamp_idx) ? clamp_anc : clamp_idx;
  assign span_hi   = (clamp_anc < clamp_idx) ? clamp_idx : clamp_anc;

  // Classify the operation
  always_comb begin
    q_wdata.kind     = KIND_NOP;
    q_wdata.bop      = BOP_QUERY;
    q_wdata.qin      = q_in;
    q_wdata.idx      = clamp_idx;
    q_wdata.lo       = clamp_idx;
    q_wdata.hi       = clamp_idx;
    q_wdata.fill_cnt = IDX_W'(1);
    q_wdata.fill_sel = q_in;
    if (n_r != '0) begin
      case (in_data.operation)
        OP_ADD: begin
          q_wdata.kind = KIND_BIT;
          q_wdata.bop  = BOP_ADD;
        end
        OP_SELECT: begin
          q_wdata.kind = KIND_FILL;
        end
        OP_TOGGLE: begin
          q_wdata.kind = q_in ? KIND_BIT : KIND_NOP;
          q_wdata.bop  = BOP_TOGGLE;
        end
        OP_RANGE: begin
          q_wdata.kind     = KIND_FILL;
          q_wdata.lo       = span_lo;
          q_wdata.hi       = span_hi;
          q_wdata.fill_cnt = IDX_W'(span_hi - span_lo + IDX_W'(1));
          q_wdata.fill_sel = q_in && (q_idx >= span_lo) && (q_idx <= span_hi);
        end
        default: begin
          // query and unused codes read one bit
          q_wdata.kind = q_in ? KIND_BIT : KIND_NOP;
          q_wdata.bop  = BOP_QUERY;
        end
      endcase
    end
  end

endmodule

// ----- src/msb_back.sv -----
// Back end: bitmap RAM, single-bit and sweep sequencer, focus, count and result register.
`timescale 1ns / 1ps
module msb_back
  import msb_pkg::*;
#(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  msb_cmd_t cmd,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  input  msb_cfg_t cfg_ev,
  input  logic     pop,
  output logic     empty,
  output msb_out_t out_data,
  output logic     busy
);

  // Row width rounded up to a power of two so bit addressing is a plain split
  localparam int OW        = $clog2(WORD_BITS);
  localparam int PW        = 1 << OW;
  localparam int NUM_WORDS = (MAX_ITEMS + PW - 1) / PW;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             init_r, init_nxt;
  logic             emit_r, emit_nxt;
  logic             fill_en_r, fill_en_nxt;
  logic             fill_sel_r, fill_sel_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  msb_cmd_t         cur_r, cur_nxt;
  logic [IDX_W-1:0] focus_r, focus_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  msb_out_t         out_r, out_nxt;

  logic [PW-1:0]    mem [NUM_WORDS];
  logic [PW-1:0]    rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [PW-1:0]    mem_wdata;

  logic [AW-1:0]    lo_w, hi_w, cur_w;
  logic [OW-1:0]    lo_o, hi_o, cur_o;
  logic [PW-1:0]    lmask, hmask, fill_word, mod_word;
  logic             in_span, old_bit, new_bit;
  logic [IDX_W-1:0] cfg_focus;

  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign busy     = init_r;

  // Split span ends and the current index into row address and bit offset
  assign lo_w  = AW'(lo_r >> OW);
  assign hi_w  = AW'(hi_r >> OW);
  assign lo_o  = lo_r[OW-1:0];
  assign hi_o  = hi_r[OW-1:0];
  assign cur_w = AW'(cur_r.idx >> OW);
  assign cur_o = cur_r.idx[OW-1:0];

  // Build the row written during a sweep
  assign in_span   = fill_en_r && (addr_r >= lo_w) && (addr_r <= hi_w);
  assign lmask     = (addr_r == lo_w) ? ({PW{1'b1}} << lo_o) : {PW{1'b1}};
  assign hmask     = (addr_r == hi_w) ? ({PW{1'b1}} >> (OW'(PW - 1) - hi_o)) : {PW{1'b1}};
  assign fill_word = in_span ? (lmask & hmask) : '0;

  // Update the addressed bit of the row just read
  assign old_bit = rdata_r[cur_o];
  always_comb begin
    case (cur_r.bop)
      BOP_ADD:    new_bit = 1'b1;
      BOP_TOGGLE: new_bit = !old_bit;
      default:    new_bit = old_bit;
    endcase
    mod_word        = rdata_r;
    mod_word[cur_o] = new_bit;
  end

  // Pull focus inside a new item count
  assign cfg_focus = (focus_r >= cfg_ev.n)
                   ? ((cfg_ev.n != '0) ? IDX_W'(cfg_ev.n - IDX_W'(1)) : '0)
                   : focus_r;

  // Sequence commands
  always_comb begin
    st_nxt        = st_r;
    addr_nxt      = addr_r;
    init_nxt      = init_r;
    emit_nxt      = emit_r;
    fill_en_nxt   = fill_en_r;
    fill_sel_nxt  = fill_sel_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    focus_nxt     = focus_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = fill_word;
    mem_raddr     = AW'(cmd.idx >> OW);

    // drop the result once taken
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (cmd_valid && !out_valid_r) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_BIT: begin
              cur_nxt = cmd;
              st_nxt  = S_MOD;
            end
            KIND_FILL: begin
              st_nxt       = S_SWEEP;
              addr_nxt     = '0;
              fill_en_nxt  = 1'b1;
              lo_nxt       = cmd.lo;
              hi_nxt       = cmd.hi;
              focus_nxt    = cmd.idx;
              count_nxt    = cmd.fill_cnt;
              fill_sel_nxt = cmd.fill_sel;
              emit_nxt     = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{is_selected: 1'b0, focus: focus_r[FOCUS_W-1:0],
                                selected_count: count_r};
            end
          endcase
        end
      end
      S_MOD: begin
        mem_we    = 1'b1;
        mem_waddr = cur_w;
        mem_wdata = mod_word;
        if (new_bit && !old_bit) begin
          count_nxt = IDX_W'(count_r + IDX_W'(1));
        end else if (old_bit && !new_bit) begin
          count_nxt = IDX_W'(count_r - IDX_W'(1));
        end
        if (cur_r.bop == BOP_ADD || (cur_r.bop == BOP_TOGGLE && new_bit)) begin
          focus_nxt = cur_r.idx;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = '{is_selected: cur_r.qin && new_bit,
                          focus: focus_nxt[FOCUS_W-1:0], selected_count: count_nxt};
        st_nxt        = S_IDLE;
      end
      S_SWEEP: begin
        mem_we = 1'b1;
        if (addr_r == LAST_ADDR) begin
          st_nxt   = S_IDLE;
          init_nxt = 1'b0;
          emit_nxt = 1'b0;
          if (emit_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{is_selected: fill_sel_r, focus: focus_r[FOCUS_W-1:0],
                              selected_count: count_r};
          end
        end else begin
          addr_nxt = AW'(addr_r + AW'(1));
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // item count write restarts a sweep that leaves only the focus bit set, or none for an empty set
    if (cfg_ev.we) begin
      st_nxt      = S_SWEEP;
      addr_nxt    = '0;
      emit_nxt    = 1'b0;
      fill_en_nxt = (cfg_ev.n != '0);
      lo_nxt      = cfg_focus;
      hi_nxt      = cfg_focus;
      focus_nxt   = cfg_focus;
      count_nxt   = (cfg_ev.n != '0) ? IDX_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_SWEEP;
      addr_r      <= '0;
      init_r      <= 1'b1;
      emit_r      <= 1'b0;
      fill_en_r   <= 1'b0;
      focus_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      addr_r      <= addr_nxt;
      init_r      <= init_nxt;
      emit_r      <= emit_nxt;
      fill_en_r   <= fill_en_nxt;
      focus_r     <= focus_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fill_sel_r <= fill_sel_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    out_r      <= out_nxt;
  end

  // Bitmap RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // No command leaves the queue during the clearing pass after reset
  a_no_cmd_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !cmd_pop)
    else $error("command taken during clearing pass");

  // A command starts only with the result slot free
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !out_valid_r)
    else $error("command started with result pending");

  // The modify step never overwrites a waiting result
  a_mod_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MOD) |-> !out_valid_r)
    else $error("bit update with result pending");

  // Sweep visits rows in order, one per cycle
  a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SWEEP && addr_r != LAST_ADDR && !cfg_ev.we)
    |=> (addr_r == AW'($past(addr_r) + AW'(1))))
    else $error("sweep address skipped");

endmodule

// ----- tb/sv/multi_select_bitmap_top_test.sv -----
// Self-checking testbench for the selection bitmap block: random and directed beats.
`timescale 1ns / 1ps
module multi_select_bitmap_top_test;
  import msb_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int SETTLE       = 80;   // past the longest sweep in the back end
  localparam int CFG_PAUSE    = 4;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_PRINTS   = 100;
  localparam int PHASE_BEATS  = 200;
  localparam int EMPTY_BEATS  = 30;
  localparam int NUM_PHASES   = 10;

  // Spare operation codes; the block treats them as a query
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // Tracks the selection state and the answers still owed by the block
  class selection_tracker;
    logic [DEF_MAX_ITEMS-1:0] sel_map;
    logic [FOCUS_W-1:0]       focus;
    logic [IDX_W-1:0]         count;
    logic [IDX_W-1:0]         n_items;
    msb_out_t                 pending_answers[$];
    int                       mismatches;

    function new();
      sel_map    = '0;
      focus      = '0;
      count      = '0;
      n_items    = '0;
      mismatches = 0;
    endfunction

    function logic [IDX_W-1:0] clamp(logic [IDX_W-1:0] i);
      return (i >= n_items) ? n_items - 1'b1 : i;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    // Saturate, clear the map, pull focus inside and mark it
    function void load_item_count(logic [IDX_W-1:0] v);
      n_items = (v > DEF_MAX_ITEMS) ? IDX_W'(DEF_MAX_ITEMS) : v;
      sel_map = '0;
      count   = '0;
      if (focus >= n_items) focus = (n_items != 0) ? FOCUS_W'(n_items - 1'b1) : '0;
      if (n_items != 0) begin
        sel_map[focus] = 1'b1;
        count          = 13'd1;
      end
    endfunction

    // Apply one accepted beat and queue the answer it must produce
    function void note_beat(msb_in_t b);
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
      msb_out_t         ans;
      int               i;
      idx = clamp(b.index);
      if (n_items != 0) begin
        case (b.operation)
          OP_ADD: begin
            if (!sel_map[idx[FOCUS_W-1:0]]) begin
              sel_map[idx[FOCUS_W-1:0]] = 1'b1;
              count = count + 1'b1;
            end
            focus = idx[FOCUS_W-1:0];
          end
          OP_SELECT: begin
            sel_map = '0;
            sel_map[idx[FOCUS_W-1:0]] = 1'b1;
            count = 13'd1;
            focus = idx[FOCUS_W-1:0];
          end
          OP_TOGGLE: begin
            // out-of-range toggles leave everything alone
            if (b.index < n_items) begin
              if (sel_map[b.index[FOCUS_W-1:0]]) begin
                sel_map[b.index[FOCUS_W-1:0]] = 1'b0;
                count = count - 1'b1;
              end else begin
                sel_map[b.index[FOCUS_W-1:0]] = 1'b1;
                count = count + 1'b1;
                focus = b.index[FOCUS_W-1:0];
              end
            end
          end
          OP_RANGE: begin
            a  = clamp(b.anchor);
            lo = (a < idx) ? a : idx;
            hi = (a < idx) ? idx : a;
            sel_map = '0;
            for (i = int'(lo); i <= int'(hi); i++) sel_map[i] = 1'b1;
            count = hi - lo + 1'b1;
            focus = idx[FOCUS_W-1:0];
          end
          default: ;
        endcase
      end
      ans.is_selected    = (b.index < n_items) ? sel_map[b.index[FOCUS_W-1:0]] : 1'b0;
      ans.focus          = focus;
      ans.selected_count = count;
      pending_answers.push_back(ans);
    endfunction

    // Compare one accepted result beat with the oldest owed answer
    task check_beat(msb_out_t got);
      msb_out_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: sel=%0d focus=%0d count=%0d",
                                  got.is_selected, got.focus, got.selected_count));
        return;
      end
      want = pending_answers.pop_front();
      if (got.is_selected !== want.is_selected)
        report_mismatch($sformatf("is_selected got %0b want %0b",
                                  got.is_selected, want.is_selected));
      if (got.focus !== want.focus)
        report_mismatch($sformatf("focus got %0d want %0d", got.focus, want.focus));
      if (got.selected_count !== want.selected_count)
        report_mismatch($sformatf("selected_count got %0d want %0d",
                                  got.selected_count, want.selected_count));
    endtask
  endclass

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             push           = 1'b0;
  msb_in_t          in_data        = '0;
  logic             pop            = 1'b0;
  logic             cfg_we         = 1'b0;
  logic [IDX_W-1:0] cfg_item_count = '0;
  logic             full;
  logic             empty;
  msb_out_t         out_data;

  selection_tracker tracker = new();
  bit               calm         = 1'b0;
  bit               hold_off_req = 1'b0;
  int unsigned      cycle_count  = 0;

  multi_select_bitmap_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_data        (in_data),
    .pop            (pop),
    .empty          (empty),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_item_count (cfg_item_count)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic push_beat(msb_in_t b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (full);
    tracker.note_beat(b);
  endtask

  // Stop offering and wait for every owed answer
  task automatic wait_drained();
    push <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_item_count(logic [IDX_W-1:0] v);
    wait_drained();
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_item_count <= v;
    @(posedge clk);
    tracker.load_item_count(v);
    cfg_we <= 1'b0;
  endtask

  function automatic msb_in_t beat(logic [OP_W-1:0] op, int idx, int anc);
    msb_in_t b;
    b.operation = op;
    b.index     = IDX_W'(idx);
    b.anchor    = IDX_W'(anc);
    return b;
  endfunction

  // Mostly in-range indices, some at the top edge, some anywhere
  function automatic logic [IDX_W-1:0] pick_index(logic [IDX_W-1:0] n);
    int r;
    r = $urandom_range(0, 99);
    if (n == 0 || r >= 85) return IDX_W'($urandom_range(0, ITEM_MAX));
    if (r >= 75) return IDX_W'($urandom_range(int'(n) - 1, int'(n) + 3));
    return IDX_W'($urandom_range(0, int'(n) - 1));
  endfunction

  function automatic msb_in_t random_beat(logic [IDX_W-1:0] n);
    msb_in_t b;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 25)      b.operation = OP_ADD;
    else if (r < 35) b.operation = OP_SELECT;
    else if (r < 65) b.operation = OP_TOGGLE;
    else if (r < 75) b.operation = OP_RANGE;
    else if (r < 88) b.operation = OP_QUERY;
    else             b.operation = OP_QUERY + OP_W'($urandom_range(1, 3));
    b.index  = pick_index(n);
    b.anchor = pick_index(n);
    return b;
  endfunction

  // Take result beats with random stalls and one long hold on request
  initial begin : result_side
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      tracker.check_beat(out_data);
    end
  end

  initial begin : stimulus
    int               p;
    int               i;
    int               beats;
    logic [IDX_W-1:0] n_val;
    logic [IDX_W-1:0] phase_vals [NUM_PHASES];
    phase_vals = '{13'd1, 13'd8191, 13'd5, 13'd64, 13'd0,
                   13'd65, 13'd4095, 13'd13, 13'd4096, 13'd0};
    phase_vals[NUM_PHASES-1] = IDX_W'($urandom_range(2, ITEM_MAX));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty set after reset: nothing changes
    push_beat(beat(OP_QUERY, 0, 0));
    push_beat(beat(OP_ADD, ITEM_MAX, ITEM_MAX));
    push_beat(beat(OP_TOGGLE, 5, 0));
    push_beat(beat(OP_RANGE, 3, 9));

    // Oversized count saturates; then walk the edges of every operation
    write_item_count(IDX_W'(ITEM_MAX));
    push_beat(beat(OP_ADD, ITEM_MAX, 0));
    push_beat(beat(OP_QUERY, 4095, 0));
    push_beat(beat(OP_TOGGLE, 4095, 0));
    push_beat(beat(OP_TOGGLE, 4095, 0));
    push_beat(beat(OP_TOGGLE, ITEM_MAX, 0));
    push_beat(beat(OP_TOGGLE, 4096, 0));
    push_beat(beat(OP_SELECT, 0, 0));
    push_beat(beat(OP_RANGE, ITEM_MAX, 0));
    push_beat(beat(OP_QUERY, 2048, ITEM_MAX));
    push_beat(beat(OP_RANGE, 0, ITEM_MAX));
    push_beat(beat(OP_RANGE, 100, 100));
    push_beat(beat(OP_ADD, 0, 0));
    push_beat(beat(OP_SELECT, ITEM_MAX, 0));
    push_beat(beat(OP_SPARE_5, 1, ITEM_MAX));
    push_beat(beat(OP_SPARE_6, 0, 0));
    push_beat(beat(OP_SPARE_7, 4095, ITEM_MAX));

    // Random phases over a spread of item counts
    for (p = 0; p < NUM_PHASES; p++) begin
      n_val = phase_vals[p];
      beats = (n_val == 0) ? EMPTY_BEATS : PHASE_BEATS;
      write_item_count(n_val);
      if (p == 2 || p == 7) hold_off_req = 1'b1;
      for (i = 0; i < beats; i++) begin
        calm = ((i / 40) % 3) == 1;
        if (i == beats / 2) wait_drained();
        push_beat(random_beat(tracker.n_items));
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
